### rtl/pcmvm_pkg.sv
`timescale 1ns / 1ps
// Package for the PCM sample voice mixer: sizes, command codes, pitch table
// and sequencer state type. It depends on nothing else.
package pcmvm_pkg;

    // Sizes of the voice bank and the sample memory.
    localparam int VOICE_COUNT  = 8;
    localparam int SAMPLE_DEPTH = 16384;

    // Fixed field widths.
    localparam int CMD_W  = 2;
    localparam int TONE_W = 3;
    localparam int SADR_W = 14;
    localparam int SVAL_W = 8;
    localparam int LEN_W  = 15;
    localparam int SNDG_W = 4;
    localparam int SKIP_W = 2;
    localparam int RUN_W  = 3;

    // Widths that follow from the sizes above.
    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int POS_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int CMP_W  = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int SUM_W  = $clog2(255 * VOICE_COUNT + 1);
    localparam int CNT_W  = $clog2(VOICE_COUNT + 1);
    localparam int DIVC_W = $clog2(SUM_W);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRIGGER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } t_state;

    // Skip value of each tone's pitch entry.
    function automatic logic [SKIP_W-1:0] pitch_skip(input logic [TONE_W-1:0] tone);
        logic [SKIP_W-1:0] skip;
        case (tone)
            3'd0:    skip = 2'd0;
            3'd6:    skip = 2'd2;
            3'd7:    skip = 2'd3;
            default: skip = 2'd1;
        endcase
        return skip;
    endfunction

    // Run-reload value of each tone's pitch entry.
    function automatic logic [RUN_W-1:0] pitch_reload(input logic [TONE_W-1:0] tone);
        logic [RUN_W-1:0] reload;
        case (tone)
            3'd1:    reload = 3'd4;
            3'd2:    reload = 3'd3;
            3'd3:    reload = 3'd2;
            3'd4:    reload = 3'd1;
            default: reload = 3'd0;
        endcase
        return reload;
    endfunction

endpackage

### rtl/pcm_sample_voice_mixer_unit.sv
`timescale 1ns / 1ps
// Eight-voice PCM sample player and mixer with one shared sample memory.
// Depends on pcmvm_pkg for sizes, command codes, pitch table and states.

// A write or trigger transfer is taken while the block is idle. A tick walks
// the voices one at a time through the single read port of the sample memory,
// each in an advance state that issues the read and then an accumulate state
// that adds the registered data, and then averages with a restoring divider
// that retires one quotient bit per cycle over the width of the sum (11 bits
// for eight voices). A tick holds the input stalled until its result is
// loaded into the output register; the divide is skipped when no voice sounds.
// The result sits in an output register, so input is taken again while it
// waits; a second tick result waits in the last step until the first has gone.
// The sample memory is not cleared after reset: a sample must be written
// before a voice plays it.
module pcm_sample_voice_mixer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: sample length register.
    input  logic                        i_cfg_we,
    input  logic [pcmvm_pkg::LEN_W-1:0] i_cfg_data,
    // Command channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pcmvm_pkg::CMD_W-1:0]  i_command,
    input  logic [pcmvm_pkg::TONE_W-1:0] i_tone,
    input  logic [pcmvm_pkg::SADR_W-1:0] i_sample_address,
    input  logic [pcmvm_pkg::SVAL_W-1:0] i_sample_value,
    // Mix result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pcmvm_pkg::SVAL_W-1:0] o_mixed_level,
    output logic [pcmvm_pkg::SNDG_W-1:0] o_voices_sounding
);
    import pcmvm_pkg::*;

    // Sample memory.
    logic [SVAL_W-1:0] r_mem [SAMPLE_DEPTH];
    logic [SVAL_W-1:0] r_rd_data;

    // Voice bank.
    logic [POS_W-1:0]  r_pos    [VOICE_COUNT];
    logic [SKIP_W-1:0] r_skip   [VOICE_COUNT];
    logic [RUN_W-1:0]  r_reload [VOICE_COUNT];
    logic [RUN_W-1:0]  r_run    [VOICE_COUNT];
    logic [VIDX_W-1:0] r_slot;

    // Sequencer and datapath registers.
    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_length;
    logic [VIDX_W-1:0] r_voice;
    logic              r_ended;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quot;
    logic [DIVC_W-1:0] r_div_cnt;
    logic              r_out_valid;
    logic [SVAL_W-1:0] r_out_level;
    logic [SNDG_W-1:0] r_out_sndg;

    // Control from the sequencer.
    logic in_xfer;
    logic last_voice;
    logic out_free;
    logic load_out;

    // Advance datapath for the voice under the voice counter.
    logic [POS_W-1:0]  cur_pos;
    logic [RUN_W-1:0]  cur_run;
    logic [RUN_W-1:0]  adv_run;
    logic [RUN_W-1:0]  adv_step;
    logic [POS_W:0]    pos_sum;
    logic [POS_W-1:0]  adv_pos;
    logic [CMP_W-1:0]  limit;
    logic              adv_ended;

    // Divider step.
    logic [CNT_W:0]    trial;
    logic              trial_ge;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign last_voice = (r_voice == VIDX_W'(VOICE_COUNT - 1));
    assign out_free   = !r_out_valid || !i_out_stall;

    // One voice step: count down the run, or skip and reload, then saturate.
    always_comb begin
        cur_pos = r_pos[r_voice];
        cur_run = r_run[r_voice];
        if (cur_run != '0) begin
            adv_step = RUN_W'(1);
            adv_run  = cur_run - RUN_W'(1);
        end else begin
            adv_step = RUN_W'(1) + RUN_W'(r_skip[r_voice]);
            adv_run  = r_reload[r_voice];
        end
        pos_sum = {1'b0, cur_pos} + (POS_W + 1)'(adv_step);
        if (pos_sum > (POS_W + 1)'(SAMPLE_DEPTH)) begin
            adv_pos = POS_W'(SAMPLE_DEPTH);
        end else begin
            adv_pos = pos_sum[POS_W-1:0];
        end
        if (CMP_W'(r_length) > CMP_W'(SAMPLE_DEPTH)) begin
            limit = CMP_W'(SAMPLE_DEPTH);
        end else begin
            limit = CMP_W'(r_length);
        end
        adv_ended = (CMP_W'(adv_pos) >= limit);
    end

    // Restoring division step: bring down one dividend bit.
    assign trial    = {r_rem, r_sum[SUM_W-1]};
    assign trial_ge = (trial >= (CNT_W + 1)'(r_count));

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer outputs.
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && (i_command == CMD_TICK)) begin
                    n_state = ST_ADV;
                end
            end
            ST_ADV: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (last_voice) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_ADV;
                end
            end
            ST_DIV: begin
                if ((r_count == '0) || (r_div_cnt == DIVC_W'(SUM_W - 1))) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sample memory: writes from the command channel, reads for the tick.
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_command == CMD_WRITE)
            && (CMP_W'(i_sample_address) < CMP_W'(SAMPLE_DEPTH))) begin
            r_mem[ADDR_W'(i_sample_address)] <= i_sample_value;
        end
        r_rd_data <= r_mem[adv_pos[ADDR_W-1:0]];
    end

    // Sample length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LEN_W'(16384);
        end else if (i_cfg_we) begin
            r_length <= i_cfg_data;
        end
    end

    // Voice bank: trigger starts the next slot, tick advances one voice.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICE_COUNT; v++) begin
                r_pos[v]    <= POS_W'(SAMPLE_DEPTH);
                r_skip[v]   <= '0;
                r_reload[v] <= '0;
                r_run[v]    <= '0;
            end
            r_slot <= '0;
        end else if (in_xfer && (i_command == CMD_TRIGGER)) begin
            r_pos[r_slot]    <= '0;
            r_skip[r_slot]   <= pitch_skip(i_tone);
            r_reload[r_slot] <= pitch_reload(i_tone);
            if (r_slot == VIDX_W'(VOICE_COUNT - 1)) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + VIDX_W'(1);
            end
        end else if (r_state == ST_ADV) begin
            r_pos[r_voice] <= adv_pos;
            r_run[r_voice] <= adv_run;
        end
    end

    // Voice walk, accumulation and division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice   <= '0;
            r_div_cnt <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_voice   <= '0;
                    r_div_cnt <= '0;
                    r_sum     <= '0;
                    r_count   <= '0;
                    r_rem     <= '0;
                    r_quot    <= '0;
                end
                ST_ADV: begin
                    r_ended <= adv_ended;
                end
                ST_ACC: begin
                    if (!r_ended && (r_rd_data != '0)) begin
                        r_sum   <= r_sum + SUM_W'(r_rd_data);
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_voice <= last_voice ? '0 : r_voice + VIDX_W'(1);
                end
                ST_DIV: begin
                    // With no sounding voice the quotient stays at zero.
                    if (r_count != '0) begin
                        if (trial_ge) begin
                            r_rem <= CNT_W'(trial - (CNT_W + 1)'(r_count));
                        end else begin
                            r_rem <= trial[CNT_W-1:0];
                        end
                        r_quot    <= {r_quot[SUM_W-2:0], trial_ge};
                        r_sum     <= {r_sum[SUM_W-2:0], 1'b0};
                        r_div_cnt <= r_div_cnt + DIVC_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: holds a finished mix until it is transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_out_level <= r_quot[SVAL_W-1:0];
            r_out_sndg  <= SNDG_W'(r_count);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_mixed_level     = r_out_level;
    assign o_voices_sounding = r_out_sndg;

    // A tick transfer always starts the voice walk.
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_command == CMD_TICK)) |=> (r_state == ST_ADV))
        else $error("tick transfer did not start the voice walk");

    // Positions saturate at the memory depth.
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADV) |=> (r_pos[$past(r_voice)] <= POS_W'(SAMPLE_DEPTH)))
        else $error("voice position went past the memory depth");

    // The divider remainder stays below the divisor.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_count != '0)) |-> (r_rem < r_count))
        else $error("divider remainder out of range");

    // The average of 8-bit samples fits in 8 bits.
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (r_quot[SUM_W-1:SVAL_W] == '0))
        else $error("mix quotient overflowed the output width");

    // A result waiting on a stall is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !load_out)
        else $error("pending result overwritten");

endmodule

### tb/pcm_sample_voice_mixer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for pcm_sample_voice_mixer_unit: drives write, trigger,
// tick and unused-command transfers with random gaps, predicts every mix result in a scoreboard class.
// Depends on pcmvm_pkg and the mixer unit RTL.
module pcm_sample_voice_mixer_unit_test;
    import pcmvm_pkg::*;

    // Command 3 has no meaning and must be ignored by the block.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Pitch table, indexed by tone: skip and run-reload of the started voice.
    localparam logic [7:0][SKIP_W-1:0] TONE_SKIP =
        {2'd3, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0};
    localparam logic [7:0][RUN_W-1:0] TONE_RELOAD =
        {3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0};

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PHASE_ITEMS = 160;

    typedef struct packed {
        logic [SVAL_W-1:0] level;
        logic [SNDG_W-1:0] sounding;
    } t_mix_result;

    // Scoreboard: a copy of the voice bank that predicts each tick's mix.
    class mix_scoreboard;
        logic [SVAL_W-1:0] sample_mem [SAMPLE_DEPTH];
        bit                written [SAMPLE_DEPTH];
        int unsigned       position [VOICE_COUNT];
        logic [SKIP_W-1:0] skip [VOICE_COUNT];
        logic [RUN_W-1:0]  reload [VOICE_COUNT];
        logic [RUN_W-1:0]  run_count [VOICE_COUNT];
        int unsigned       next_slot;
        logic [LEN_W-1:0]  length;
        t_mix_result       expected_mix [$];
        int unsigned       mismatches;

        function new();
            length = LEN_W'(SAMPLE_DEPTH);
            for (int v = 0; v < VOICE_COUNT; v++) begin
                position[v] = SAMPLE_DEPTH;
                skip[v] = '0;
                reload[v] = '0;
                run_count[v] = '0;
            end
            next_slot = 0;
            mismatches = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] value);
            length = value;
        endfunction

        // A voice ends at the sample length, never beyond the memory.
        function int unsigned end_limit();
            return (length > SAMPLE_DEPTH) ? SAMPLE_DEPTH : int'(length);
        endfunction

        // Position the voice reaches on its next tick; it saturates at the depth.
        function int unsigned stepped_position(int v);
            int unsigned p;
            p = position[v] + ((run_count[v] != 0) ? 1 : 1 + skip[v]);
            return (p > SAMPLE_DEPTH) ? SAMPLE_DEPTH : p;
        endfunction

        function int unsigned pending();
            return expected_mix.size();
        endfunction

        // Update the voice bank for one accepted command transfer.
        function void note_command(logic [CMD_W-1:0] cmd, logic [TONE_W-1:0] tone,
                                   logic [SADR_W-1:0] addr, logic [SVAL_W-1:0] val);
            int unsigned sum;
            int unsigned count;
            int unsigned lim;
            int unsigned slot;
            t_mix_result r;
            case (cmd)
                CMD_TICK: begin
                    sum = 0;
                    count = 0;
                    lim = end_limit();
                    for (int v = 0; v < VOICE_COUNT; v++) begin
                        position[v] = stepped_position(v);
                        if (run_count[v] != 0) run_count[v] = run_count[v] - 1'b1;
                        else run_count[v] = reload[v];
                        if (position[v] < lim && sample_mem[position[v]] != 0) begin
                            sum += sample_mem[position[v]];
                            count++;
                        end
                    end
                    r.level = SVAL_W'((count != 0) ? sum / count : 0);
                    r.sounding = SNDG_W'(count);
                    expected_mix.push_back(r);
                end
                CMD_TRIGGER: begin
                    // The run counter of the restarted voice is left as it was.
                    slot = next_slot % VOICE_COUNT;
                    skip[slot] = TONE_SKIP[tone];
                    reload[slot] = TONE_RELOAD[tone];
                    position[slot] = 0;
                    next_slot = (slot + 1) % VOICE_COUNT;
                end
                CMD_WRITE: begin
                    sample_mem[addr] = val;
                    written[addr] = 1'b1;
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one accepted mix result with the oldest prediction.
        function void check_mix(logic [SVAL_W-1:0] level, logic [SNDG_W-1:0] sounding);
            t_mix_result e;
            if (expected_mix.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected mix result: level %0d sounding %0d",
                             level, sounding);
                return;
            end
            e = expected_mix.pop_front();
            if (e.level !== level || e.sounding !== sounding) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mix mismatch: expected level %0d sounding %0d, got %0d %0d",
                             e.level, e.sounding, level, sounding);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [LEN_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_command = CMD_TICK;
    logic [TONE_W-1:0]  i_tone = '0;
    logic [SADR_W-1:0]  i_sample_address = '0;
    logic [SVAL_W-1:0]  i_sample_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [SVAL_W-1:0]  o_mixed_level;
    logic [SNDG_W-1:0]  o_voices_sounding;

    mix_scoreboard sb;
    bit            calm = 1'b0;
    int unsigned   cycle_count = 0;

    pcm_sample_voice_mixer_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_tone            (i_tone),
        .i_sample_address  (i_sample_address),
        .i_sample_value    (i_sample_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_mixed_level     (o_mixed_level),
        .o_voices_sounding (o_voices_sounding)
    );

    always #6 i_clk = ~i_clk;

    // Run limit: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Sample values: zero now and then so that silent reads are exercised.
    function automatic logic [SVAL_W-1:0] fresh_sample();
        return ($urandom_range(0, 7) == 0) ? '0 : SVAL_W'($urandom_range(1, 255));
    endfunction

    // One command transfer after a random gap; valid stays high until accepted.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [TONE_W-1:0] tone,
                                input logic [SADR_W-1:0] addr, input logic [SVAL_W-1:0] val);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_tone           <= tone;
        i_sample_address <= addr;
        i_sample_value   <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_command(cmd, tone, addr, val);
    endtask

    // A tick, preceded by writes of any sample entry a voice is about to read
    // for the first time, so that no unwritten entry is ever played.
    task automatic send_tick();
        int unsigned p;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            p = sb.stepped_position(v);
            if (p < sb.end_limit() && !sb.written[p])
                send_command(CMD_WRITE, TONE_W'($urandom_range(0, 7)), SADR_W'(p),
                             fresh_sample());
        end
        send_command(CMD_TICK, TONE_W'($urandom_range(0, 7)),
                     SADR_W'($urandom_range(0, SAMPLE_DEPTH - 1)),
                     SVAL_W'($urandom_range(0, 255)));
    endtask

    // Hold the sender off until every predicted result has arrived.
    task automatic wait_for_results(input bit settle);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sample_length(input logic [LEN_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_length(value);
    endtask

    // One random command, mostly ticks and triggers so voices keep sounding.
    task automatic send_random_command();
        int unsigned pick;
        int unsigned lim;
        logic [SADR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        lim = sb.end_limit();
        if (pick < 55) begin
            send_tick();
        end else if (pick < 75) begin
            send_command(CMD_TRIGGER, TONE_W'($urandom_range(0, 7)),
                         SADR_W'($urandom_range(0, SAMPLE_DEPTH - 1)),
                         SVAL_W'($urandom_range(0, 255)));
        end else if (pick < 95) begin
            // Most writes land where the voices play; the rest anywhere.
            if (lim != 0 && $urandom_range(0, 9) < 7)
                addr = SADR_W'($urandom_range(0, lim - 1));
            else
                addr = SADR_W'($urandom_range(0, SAMPLE_DEPTH - 1));
            send_command(CMD_WRITE, TONE_W'($urandom_range(0, 7)), addr, fresh_sample());
        end else begin
            send_command(CMD_UNUSED, TONE_W'($urandom_range(0, 7)),
                         SADR_W'($urandom_range(0, SAMPLE_DEPTH - 1)),
                         SVAL_W'($urandom_range(0, 255)));
        end
    endtask

    // Result side: a random stall before each transfer, then check it.
    initial begin
        int unsigned hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 11);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_mix(o_mixed_level, o_voices_sounding);
        end
    end

    // Main sequence: reset, directed commands, then phases of sample lengths.
    initial begin
        logic [LEN_W-1:0] lengths [10];
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ticks with every voice ended and saturated at the depth,
        // an unused command with all fields high, and extreme writes.
        send_tick();
        send_tick();
        send_command(CMD_UNUSED, '1, '1, '1);
        send_command(CMD_WRITE, '0, '0, 8'd255);
        send_command(CMD_WRITE, '1, '1, '0);
        send_command(CMD_WRITE, '0, '1, 8'd255);
        // Every tone once, filling all slots.
        for (int t = 0; t < 8; t++)
            send_command(CMD_TRIGGER, TONE_W'(t), '0, '0);
        repeat (6) send_tick();
        // The slot wraps to the first voice, which keeps its run counter.
        send_command(CMD_TRIGGER, TONE_W'(3), '1, '1);
        send_command(CMD_WRITE, '0, SADR_W'(2), '0);
        repeat (3) send_tick();

        lengths = '{15'd40, 15'd0, 15'd1, 15'd16384, 15'd32767, 15'd200, 15'd16383,
                    LEN_W'($urandom_range(2, 400)), 15'd9,
                    LEN_W'($urandom_range(0, 32767))};
        foreach (lengths[k]) begin
            wait_for_results(1'b1);
            write_sample_length(lengths[k]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 32 == 0) calm = ($urandom_range(0, 3) == 0);
                // Hold the sender off once per phase until the results catch up.
                if (n == PHASE_ITEMS / 2) wait_for_results(1'b0);
                send_random_command();
            end
        end
        calm = 1'b0;

        wait_for_results(1'b1);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
